// ===== src/css_pkg.sv =====
// Shared types and constants of the cursor sequence store.
package css_pkg;

   localparam int DEPTH     = 64;
   localparam int WORD_BITS = 32;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      OP_START   = 3'd0,
      OP_ADVANCE = 3'd1,
      OP_INSERT  = 3'd2,
      OP_ATTACH  = 3'd3,
      OP_REMOVE  = 3'd4
   } op_code_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NO_CURRENT = 2'd1,
      ST_FULL       = 2'd2
   } status_code_type;

   typedef enum logic [1:0] {
      ROUTE_LOOKUP,
      ROUTE_GROW,
      ROUTE_SHRINK
   } route_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_UP_RD,
      S_UP_WR,
      S_DN_RD,
      S_DN_WR,
      S_LOOKUP,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] entry_value;
   } req_word_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [CNT_BITS-1:0] item_count;
      logic                has_current;
      logic [31:0]         current_value;
   } rsp_word_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic up_read;
      logic up_write;
      logic put;
      logic dn_read;
      logic dn_write;
      logic shrink;
      logic lookup;
   } dp_cmd_type;

   typedef struct packed {
      route_type route;
      logic      grow_more;
      logic      shrink_more;
   } dp_stat_type;

endpackage

// ===== src/cursor_sequence_store.sv =====
// Top level of the cursor sequence store: ordered word list with a cursor.
// Start, advance, refused and unknown requests pass from evaluation straight to lookup and reply.
// Insert/attach first shift the entries from the position to the end up by one; remove shifts
// the entries behind the cursor down by one. One request at a time: the next is taken in the
// cycle after the strobe, each shifted entry taking a registered read, then the write.
// Reset clears count, cursor and controller state; entries hold garbage until written.
module cursor_sequence_store (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  css_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   output css_pkg::rsp_word_type rsp_data
);

   // Command and status between controller and datapath.
   css_pkg::dp_cmd_type  cmd;
   css_pkg::dp_stat_type stat;

   // Sequence each request: evaluate, shift entries, read the cursor word, reply.
   css_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Hold entries, count and cursor; produce the result word.
   css_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

`ifndef SYNTH
   // An accepted word must raise busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset) start && !busy |=> busy)
      else $error("busy did not rise after accept");

   // A result is shown for one cycle only.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe held too long");

   // Count never exceeds the store depth.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.item_count <= css_pkg::CNT_BITS'(css_pkg::DEPTH))
      else $error("count beyond depth");

   // No current entry means a zero word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_current |-> rsp_data.current_value == 32'd0)
      else $error("value without current entry");

   // The strobe comes only while busy.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result while idle");
`endif

endmodule

// ===== src/css_datapath.sv =====
// Datapath of the cursor sequence store: entry memory, count, cursor and shift index.
module css_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  css_pkg::req_word_type req_data,
   input  css_pkg::dp_cmd_type   cmd,
   output css_pkg::dp_stat_type  stat,
   output css_pkg::rsp_word_type rsp_data
);

   localparam logic [css_pkg::CNT_BITS-1:0] CNT_ONE  = css_pkg::CNT_BITS'(1);
   localparam logic [css_pkg::CNT_BITS-1:0] CNT_FULL = css_pkg::CNT_BITS'(css_pkg::DEPTH);

   logic [css_pkg::WORD_BITS-1:0] mem [css_pkg::DEPTH];

   css_pkg::op_code_type          op_ff, op_in;
   logic [css_pkg::WORD_BITS-1:0] word_ff, word_in;
   logic [css_pkg::CNT_BITS-1:0]  count_ff, count_in;
   logic [css_pkg::CNT_BITS-1:0]  cursor_ff, cursor_in;
   logic [css_pkg::CNT_BITS-1:0]  idx_ff, idx_in;
   css_pkg::status_code_type      status_ff, status_in;
   logic [css_pkg::WORD_BITS-1:0] rdata_ff;

   logic                          current;
   logic                          full;
   logic [css_pkg::CNT_BITS-1:0]  idx_dec;
   logic [css_pkg::CNT_BITS-1:0]  idx_inc;
   logic [css_pkg::CNT_BITS-1:0]  rd_addr;
   logic [css_pkg::CNT_BITS-1:0]  wr_addr;
   logic [css_pkg::WORD_BITS-1:0] wr_data;
   logic                          wr_en;
   logic                          rd_en;

   assign current = cursor_ff < count_ff;
   assign full    = count_ff == CNT_FULL;
   assign idx_dec = idx_ff - CNT_ONE;
   assign idx_inc = idx_ff + CNT_ONE;

   // Decide the path of the held request.
   always_comb begin
      stat.route = css_pkg::ROUTE_LOOKUP;
      case (op_ff)
         css_pkg::OP_INSERT, css_pkg::OP_ATTACH: begin
            if (!full) begin
               stat.route = css_pkg::ROUTE_GROW;
            end
         end
         css_pkg::OP_REMOVE: begin
            if (current) begin
               stat.route = css_pkg::ROUTE_SHRINK;
            end
         end
         default: begin
            stat.route = css_pkg::ROUTE_LOOKUP;
         end
      endcase
      stat.grow_more   = idx_ff > cursor_ff;
      stat.shrink_more = idx_inc < count_ff;
   end

   always_comb begin
      op_in     = op_ff;
      word_in   = word_ff;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      if (cmd.capture) begin
         op_in   = css_pkg::op_code_type'(req_data.req_type);
         word_in = css_pkg::WORD_BITS'(req_data.entry_value);
      end
      if (cmd.eval) begin
         status_in = css_pkg::ST_OK;
         case (op_ff)
            css_pkg::OP_START: begin
               cursor_in = '0;
            end
            css_pkg::OP_ADVANCE: begin
               if (current) begin
                  cursor_in = cursor_ff + CNT_ONE;
               end else begin
                  status_in = css_pkg::ST_NO_CURRENT;
               end
            end
            css_pkg::OP_INSERT: begin
               if (full) begin
                  status_in = css_pkg::ST_FULL;
               end else begin
                  cursor_in = current ? cursor_ff : '0;
                  idx_in    = count_ff;
               end
            end
            css_pkg::OP_ATTACH: begin
               if (full) begin
                  status_in = css_pkg::ST_FULL;
               end else begin
                  cursor_in = current ? cursor_ff + CNT_ONE : count_ff;
                  idx_in    = count_ff;
               end
            end
            css_pkg::OP_REMOVE: begin
               if (current) begin
                  idx_in = cursor_ff;
               end else begin
                  status_in = css_pkg::ST_NO_CURRENT;
               end
            end
            default: begin
               status_in = css_pkg::ST_OK;
            end
         endcase
      end
      if (cmd.up_write) begin
         idx_in = idx_dec;
      end
      if (cmd.dn_write) begin
         idx_in = idx_inc;
      end
      if (cmd.put) begin
         count_in = count_ff + CNT_ONE;
      end
      if (cmd.shrink) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   // One read and one write port on the entry memory.
   always_comb begin
      rd_en   = cmd.up_read | cmd.dn_read | cmd.lookup;
      rd_addr = cursor_ff;
      if (cmd.up_read) begin
         rd_addr = idx_dec;
      end else if (cmd.dn_read) begin
         rd_addr = idx_inc;
      end
      wr_en   = cmd.up_write | cmd.dn_write | cmd.put;
      wr_addr = cmd.put ? cursor_ff : idx_ff;
      wr_data = cmd.put ? word_ff : rdata_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[css_pkg::ADDR_BITS-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr[css_pkg::ADDR_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cursor_ff <= '0;
      end else begin
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
      end
      op_ff     <= op_in;
      word_ff   <= word_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
   end

   assign rsp_data.status        = status_ff;
   assign rsp_data.item_count    = count_ff;
   assign rsp_data.has_current   = current;
   assign rsp_data.current_value = current ? 32'(rdata_ff) : 32'd0;

endmodule

// ===== src/css_ctrl.sv =====
// Controller of the cursor sequence store: sequences evaluation, shifts and lookup.
module css_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  css_pkg::dp_stat_type stat,
   output css_pkg::dp_cmd_type  cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   css_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= css_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         css_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = css_pkg::S_EVAL;
            end
         end
         css_pkg::S_EVAL: begin
            cmd.eval = 1'b1;
            case (stat.route)
               css_pkg::ROUTE_GROW:   state_in = css_pkg::S_UP_RD;
               css_pkg::ROUTE_SHRINK: state_in = css_pkg::S_DN_RD;
               default:               state_in = css_pkg::S_LOOKUP;
            endcase
         end
         css_pkg::S_UP_RD: begin
            if (stat.grow_more) begin
               cmd.up_read = 1'b1;
               state_in    = css_pkg::S_UP_WR;
            end else begin
               cmd.put  = 1'b1;
               state_in = css_pkg::S_LOOKUP;
            end
         end
         css_pkg::S_UP_WR: begin
            cmd.up_write = 1'b1;
            state_in     = css_pkg::S_UP_RD;
         end
         css_pkg::S_DN_RD: begin
            if (stat.shrink_more) begin
               cmd.dn_read = 1'b1;
               state_in    = css_pkg::S_DN_WR;
            end else begin
               cmd.shrink = 1'b1;
               state_in   = css_pkg::S_LOOKUP;
            end
         end
         css_pkg::S_DN_WR: begin
            cmd.dn_write = 1'b1;
            state_in     = css_pkg::S_DN_RD;
         end
         css_pkg::S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = css_pkg::S_REPLY;
         end
         css_pkg::S_REPLY: begin
            rsp_valid = 1'b1;
            state_in  = css_pkg::S_IDLE;
         end
         default: begin
            state_in = css_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the cursor sequence store: directed and random request words.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // The slowest correct run is about 1900 words.
   // Allow a few times its length before giving up.
   localparam int CYCLE_LIMIT   = 1_000_000;
   // Once the queue is empty, only strays can still show up, so a short watch is enough.
   localparam int DRAIN_CYCLES  = 16;
   localparam int REPORT_LIMIT  = 60;
   // Request codes above the last defined operation are accepted and ignored.
   localparam int FIRST_UNUSED_OP = css_pkg::OP_REMOVE + 1;
   localparam int LAST_OP_CODE    = 7;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   css_pkg::req_word_type req_data;
   logic                  rsp_valid;
   css_pkg::rsp_word_type rsp_data;

   // Local copy of the list: words, number held and cursor position.
   logic [css_pkg::WORD_BITS-1:0] list_words [css_pkg::DEPTH];
   int                            list_count;
   int                            list_cursor;

   css_pkg::rsp_word_type expected_replies[$];
   int                    mismatch_count;
   int                    cycles_run;
   bit                    sender_idles;

   cursor_sequence_store uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Apply one request to the local list and return the reply it must produce.
   function automatic css_pkg::rsp_word_type predict_reply(input css_pkg::req_word_type w);
      css_pkg::rsp_word_type r;
      logic                  on_entry;
      on_entry = list_cursor < list_count;
      r.status = css_pkg::ST_OK;
      case (w.req_type)
         css_pkg::OP_START: begin
            list_cursor = 0;
         end
         css_pkg::OP_ADVANCE: begin
            if (on_entry) begin
               list_cursor++;
            end else begin
               r.status = css_pkg::ST_NO_CURRENT;
            end
         end
         css_pkg::OP_INSERT, css_pkg::OP_ATTACH: begin
            if (list_count >= css_pkg::DEPTH) begin
               r.status = css_pkg::ST_FULL;
            end else begin
               // Insert lands before the current entry, or at the front without one.
               // Attach lands after it, or at the end without one.
               if (w.req_type == css_pkg::OP_INSERT) begin
                  if (!on_entry) list_cursor = 0;
               end else begin
                  list_cursor = on_entry ? list_cursor + 1 : list_count;
               end
               for (int i = list_count; i > list_cursor; i--) list_words[i] = list_words[i-1];
               list_words[list_cursor] = w.entry_value[css_pkg::WORD_BITS-1:0];
               list_count++;
            end
         end
         css_pkg::OP_REMOVE: begin
            if (on_entry) begin
               // Close the gap. The follower, if any, becomes current.
               for (int i = list_cursor; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
               list_count--;
            end else begin
               r.status = css_pkg::ST_NO_CURRENT;
            end
         end
         default: begin
         end
      endcase
      r.item_count    = css_pkg::CNT_BITS'(list_count);
      r.has_current   = list_cursor < list_count;
      r.current_value = r.has_current ? 32'(list_words[list_cursor]) : '0;
      return r;
   endfunction

   function automatic css_pkg::req_word_type make_word(input logic [2:0] op,
                                                       input logic [31:0] value);
      css_pkg::req_word_type w;
      w.req_type    = op;
      w.entry_value = value;
      return w;
   endfunction

   // Pick a random request. grow_pct and shrink_pct steer the list size. The rest
   // moves the cursor, and a small share is unused codes.
   function automatic css_pkg::req_word_type random_word(input int grow_pct,
                                                         input int shrink_pct);
      css_pkg::req_word_type w;
      int                    pick;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 15))
         0:       w.entry_value = '0;
         1:       w.entry_value = '1;
         2:       w.entry_value = 32'd1 << $urandom_range(0, 31);
         default: w.entry_value = $urandom;
      endcase
      if (pick < 3) begin
         w.req_type = 3'($urandom_range(FIRST_UNUSED_OP, LAST_OP_CODE));
      end else if (pick < 3 + grow_pct) begin
         w.req_type = ($urandom_range(0, 1) != 0) ? css_pkg::OP_INSERT : css_pkg::OP_ATTACH;
      end else if (pick < 3 + grow_pct + shrink_pct) begin
         w.req_type = css_pkg::OP_REMOVE;
      end else if ($urandom_range(0, 4) == 0) begin
         w.req_type = css_pkg::OP_START;
      end else begin
         w.req_type = css_pkg::OP_ADVANCE;
      end
      return w;
   endfunction

   // Present one word and hold it until the store takes it. A word is taken at an edge
   // that sees start high and busy low. Enqueue its predicted reply at that edge.
   task automatic send_word(input css_pkg::req_word_type w);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_data <= w;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_replies.push_back(predict_reply(w));
   endtask

   // On an empty store, advance and remove are refused; start is accepted. Unused codes change nothing.
   task automatic test_empty_store();
      send_word(make_word(css_pkg::OP_START, '0));
      send_word(make_word(css_pkg::OP_ADVANCE, '1));
      send_word(make_word(css_pkg::OP_REMOVE, '1));
      for (int c = FIRST_UNUSED_OP; c <= LAST_OP_CODE; c++) send_word(make_word(3'(c), '1));
   endtask

   // Walk through every edit position by hand: front, end, middle, past the end.
   task automatic test_cursor_edits();
      send_word(make_word(css_pkg::OP_INSERT, 32'h0000_0000));   // empty list: lands at the front
      send_word(make_word(css_pkg::OP_ATTACH, 32'hFFFF_FFFF));   // after current
      send_word(make_word(css_pkg::OP_INSERT, 32'h8000_0001));   // before current
      send_word(make_word(css_pkg::OP_ADVANCE, '0));
      send_word(make_word(css_pkg::OP_ADVANCE, '0));             // step off the end
      send_word(make_word(css_pkg::OP_ADVANCE, '0));             // refused: no current entry
      send_word(make_word(css_pkg::OP_ATTACH, 32'h0000_0001));   // no current: lands at the end
      send_word(make_word(css_pkg::OP_REMOVE, '0));              // last entry, nothing follows
      send_word(make_word(css_pkg::OP_REMOVE, '0));              // refused
      send_word(make_word(css_pkg::OP_INSERT, 32'h5A5A_A5A5));   // no current: lands at the front
      send_word(make_word(css_pkg::OP_START, '0));
      send_word(make_word(css_pkg::OP_ADVANCE, '0));
      send_word(make_word(css_pkg::OP_REMOVE, '0));              // follower becomes current
      send_word(make_word(css_pkg::OP_ATTACH, 32'h7FFF_FFFE));
      send_word(make_word(css_pkg::OP_START, '0));
      send_word(make_word(css_pkg::OP_REMOVE, '0));              // drop the front entry
      send_word(make_word(3'(LAST_OP_CODE), 32'hDEAD_BEEF));
   endtask

   // Mixed traffic. Growth outweighs removal, so the list spends time near full.
   // Toggle sender idling now and then to leave long stretches without gaps.
   task automatic test_random_walk(input int words);
      for (int n = 0; n < words; n++) begin
         if (n % 64 == 0) sender_idles = $urandom_range(0, 3) != 0;
         send_word(random_word(40, 30));
      end
   endtask

   // Fill the store to the top and push against it, then drain it to empty.
   task automatic test_fill_and_drain(input int rounds);
      sender_idles = 1'b1;
      repeat (rounds) begin
         while (list_count < css_pkg::DEPTH) send_word(random_word(70, 5));
         repeat (12) send_word(random_word(60, 0));
         send_word(make_word(css_pkg::OP_START, '0));
         while (list_count > 0) send_word(random_word(5, 65));
      end
   endtask

   // Closing stretch: words back to back, no sender gaps at all.
   task automatic test_back_to_back(input int words);
      sender_idles = 1'b0;
      repeat (words) send_word(random_word(40, 30));
   endtask

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      end
   endfunction

   // Take each strobed reply at the edge that ends its cycle. Match it with the oldest
   // outstanding prediction.
   always @(posedge clock) begin : check_reply
      css_pkg::rsp_word_type want;
      if (!reset && rsp_valid) begin
         if (expected_replies.size() == 0) begin
            mismatch_count++;
            $error("reply word strobed with no request outstanding");
         end else begin
            want = expected_replies.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("item_count", 32'(want.item_count), 32'(rsp_data.item_count));
            check_field("has_current", 32'(want.has_current), 32'(rsp_data.has_current));
            check_field("current_value", want.current_value, rsp_data.current_value);
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run > CYCLE_LIMIT) begin
         $display("cursor_sequence_store verification failed");
         $finish;
      end
   end

   initial begin
      mismatch_count = 0;
      cycles_run     = 0;
      list_count     = 0;
      list_cursor    = 0;
      sender_idles   = 1'b1;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_cursor_edits();
      test_random_walk(1100);
      test_fill_and_drain(2);
      test_back_to_back(400);
      start <= 1'b0;

      // Let the last replies arrive, then watch a little longer for strays.
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_replies.size() == 0) begin
         $display("cursor_sequence_store verification clean");
      end else begin
         $display("cursor_sequence_store verification failed");
      end
      $finish;
   end

endmodule

// ===== cursor_sequence_store.f =====
src/css_pkg.sv
src/css_datapath.sv
src/css_ctrl.sv
src/cursor_sequence_store.sv
bench/testbench.sv
